>>> rtl/tlt_pkg.sv
// ----------------------------------------------------------------------------
// tlt_pkg : shared types and constants of the triangle LFO tremolo
// Fixed-point formats, register indexes and reset values, and the command
// bundle passed from controller to datapath.
// ----------------------------------------------------------------------------
package tlt_pkg;

   // Audio sample width default
   localparam int SAMPLE_BITS_DEF = 24;

   // Q15 fixed point
   localparam int Q_FRAC     = 15;
   localparam int DEPTH_FULL = 32768;

   // Register widths
   localparam int DEPTH_W  = 16;
   localparam int LIMIT_W  = 14;
   localparam int COUNT_W  = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT = 2'd1;

   // Reset values
   localparam int DEPTH_RESET = 16384;
   localparam int LIMIT_RESET = 6000;

   // Fraction bits produced by the serial divider
   localparam int DIV_STEPS = 15;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Gain in signed Q15, range [-1.0, +1.0]
   localparam int GAIN_W = 18;

   // Controller to datapath commands
   typedef struct packed {
      logic load;      // capture sample, start divide, step LFO
      logic div_step;  // one quotient bit
      logic mul_gain;  // depth times ratio
      logic mul_prod;  // sample times gain
      logic out_load;  // saturate into the output register
   } cmd_type;

endpackage

>>> rtl/tlt_ctrl.sv
// ----------------------------------------------------------------------------
// tlt_ctrl : sequencer of the tremolo
// Steps one transaction through divide, gain, product and output phases,
// and owns the handshake state of both channels.
// ----------------------------------------------------------------------------
module tlt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tlt_pkg::cmd_type cmd
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIV  = 5'b00010,
      ST_GAIN = 5'b00100,
      ST_PROD = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type                       state_ff, state_in;
   logic [tlt_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = tlt_pkg::DIV_CNT_W'(tlt_pkg::DIV_STEPS - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_GAIN;
            end
         end
         ST_GAIN: begin
            cmd.mul_gain = 1'b1;
            state_in     = ST_PROD;
         end
         ST_PROD: begin
            cmd.mul_prod = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output valid flag
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

endmodule

>>> rtl/tlt_dp.sv
// ----------------------------------------------------------------------------
// tlt_dp : datapath of the tremolo
// Holds the settings and the triangle LFO, runs a bit-serial divider for
// count/limit, forms the gain, multiplies and saturates the sample.
// ----------------------------------------------------------------------------
module tlt_dp #(
   parameter int SAMPLE_BITS = tlt_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tlt_pkg::cmd_type                      cmd,
   input  logic                                  csr_we,
   input  logic [tlt_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [tlt_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample_in,
   output logic signed [SAMPLE_BITS-1:0]         rsp_sample_out
);

   localparam int LW   = tlt_pkg::LIMIT_W;
   localparam int CW   = tlt_pkg::COUNT_W;
   localparam int GW   = tlt_pkg::GAIN_W;
   localparam int QF   = tlt_pkg::Q_FRAC;
   localparam int PW   = SAMPLE_BITS + GW;
   localparam int TOPW = PW - QF - SAMPLE_BITS + 1;

   // Settings and LFO state
   logic [tlt_pkg::DEPTH_W:0]     depth_ff, depth_in;
   logic [LW-1:0]                 limit_ff, limit_in;
   logic signed [CW-1:0]          count_ff, count_in;
   logic                          falling_ff, falling_in;

   // Per-transaction working registers
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic                          neg_ff;
   logic                          full_ff;
   logic [LW-1:0]                 rem_ff;
   logic [tlt_pkg::DIV_STEPS-1:0] quo_ff;
   logic signed [31:0]            dr_ff;
   logic signed [PW-1:0]          prod_ff;
   logic signed [SAMPLE_BITS-1:0] out_ff;

   logic [tlt_pkg::DEPTH_W-1:0]   wr_depth;
   logic [LW-1:0]                 wr_limit;
   logic signed [CW-1:0]          lim_s;
   logic signed [CW-1:0]          cnt_mag_s;
   logic [LW-1:0]                 mag;
   logic [LW:0]                   trial;
   logic                          qbit;
   logic [15:0]                   r_mag;
   logic signed [16:0]            r_val;
   logic signed [34:0]            dr_full;
   logic signed [31:0]            dr_sh;
   logic signed [GW-1:0]          g_val;
   logic signed [PW-1:0]          prod_full;
   logic [TOPW-1:0]               top_bits;
   logic signed [SAMPLE_BITS-1:0] sat_val;

   // Register writes with range limits; limit write clamps the counter
   always_comb begin
      depth_in   = depth_ff;
      limit_in   = limit_ff;
      count_in   = count_ff;
      falling_in = falling_ff;
      wr_depth   = csr_wdata[tlt_pkg::DEPTH_W-1:0];
      wr_limit   = csr_wdata[LW-1:0];
      if (wr_limit == '0) begin
         wr_limit = LW'(1);
      end
      lim_s = signed'(CW'(limit_ff));
      // LFO step on accept, using the counter value from before the step
      if (cmd.load) begin
         if (count_ff >= lim_s) begin
            falling_in = 1'b1;
         end else if (count_ff <= -lim_s) begin
            falling_in = 1'b0;
         end
         count_in = falling_in ? count_ff - 1'b1 : count_ff + 1'b1;
      end
      if (csr_we) begin
         case (csr_index)
            tlt_pkg::CSR_DEPTH: begin
               if (wr_depth > 16'(tlt_pkg::DEPTH_FULL)) begin
                  depth_in = (tlt_pkg::DEPTH_W + 1)'(tlt_pkg::DEPTH_FULL);
               end else begin
                  depth_in = {1'b0, wr_depth};
               end
            end
            tlt_pkg::CSR_LIMIT: begin
               limit_in = wr_limit;
               if (count_ff > signed'(CW'(wr_limit))) begin
                  count_in = signed'(CW'(wr_limit));
               end else if (count_ff < -signed'(CW'(wr_limit))) begin
                  count_in = -signed'(CW'(wr_limit));
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff   <= (tlt_pkg::DEPTH_W + 1)'(tlt_pkg::DEPTH_RESET);
         limit_ff   <= LW'(tlt_pkg::LIMIT_RESET);
         count_ff   <= '0;
         falling_ff <= 1'b0;
      end else begin
         depth_ff   <= depth_in;
         limit_ff   <= limit_in;
         count_ff   <= count_in;
         falling_ff <= falling_in;
      end
   end

   // Counter magnitude; always within the limit, so 14 bits
   assign cnt_mag_s = (count_ff < 0) ? -count_ff : count_ff;
   assign mag       = cnt_mag_s[LW-1:0];

   // One restoring divide step: fraction bit of rem/limit
   assign trial = {rem_ff, 1'b0};
   assign qbit  = (trial >= {1'b0, limit_ff});

   // Ratio in Q1.15, full scale when the counter sits on the limit
   assign r_mag   = full_ff ? 16'(tlt_pkg::DEPTH_FULL) : {1'b0, quo_ff};
   assign r_val   = neg_ff ? -signed'({1'b0, r_mag}) : signed'({1'b0, r_mag});
   assign dr_full = 35'(signed'({1'b0, depth_ff})) * 35'(r_val);

   // Gain = (1 - d) + floor(d * r), then sample times gain
   assign dr_sh     = dr_ff >>> QF;
   assign g_val     = signed'(GW'(tlt_pkg::DEPTH_FULL)) - signed'({1'b0, depth_ff})
                      + signed'(dr_sh[GW-1:0]);
   assign prod_full = PW'(sample_ff) * PW'(g_val);

   // Drop 15 fraction bits and saturate to the sample range
   assign top_bits = prod_ff[PW-1:QF+SAMPLE_BITS-1];
   always_comb begin
      if ((&top_bits) || !(|top_bits)) begin
         sat_val = prod_ff[QF+SAMPLE_BITS-1:QF];
      end else if (prod_ff[PW-1]) begin
         sat_val = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         sat_val = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff <= req_sample_in;
         neg_ff    <= (count_ff < 0);
         full_ff   <= (mag >= limit_ff);
         rem_ff    <= mag;
         quo_ff    <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= qbit ? LW'(trial - {1'b0, limit_ff}) : trial[LW-1:0];
         quo_ff <= {quo_ff[tlt_pkg::DIV_STEPS-2:0], qbit};
      end
      if (cmd.mul_gain) begin
         dr_ff <= dr_full[31:0];
      end
      if (cmd.mul_prod) begin
         prod_ff <= prod_full;
      end
      if (cmd.out_load) begin
         out_ff <= sat_val;
      end
   end

   assign rsp_sample_out = out_ff;

endmodule

>>> rtl/triangle_lfo_tremolo.sv
// ----------------------------------------------------------------------------
// triangle_lfo_tremolo : triangle LFO amplitude modulation of audio samples
// Scales each sample by (1 - depth) + depth * count / limit, where count is
// a triangle wave stepping by one per sample between -limit and +limit.
//
// Input channel (req_*): one signed sample per transaction, valid/ready.
// Result channel (rsp_*): one modulated, saturated sample per transaction.
// Settings port (csr_*): index 0 is depth in Q1.15 (32768 = full depth,
// larger values stored as full), index 1 is the triangle peak (0 stored
// as 1; writing it clamps the counter into range). Write only while idle.
//
// Each accepted sample passes through the 15-step bit-serial divider that
// forms count/limit, then the gain, product and output stages; a new sample
// is accepted only once the previous one has reached the output register.
// The output register frees the datapath: the next sample is accepted and
// processed while a result waits; if the receiver stalls, the following
// result holds in the datapath until the output register is taken.
// Reset (synchronous): depth 16384, limit 6000, counter zero and rising,
// no result pending.
// ----------------------------------------------------------------------------
module triangle_lfo_tremolo #(
   parameter int SAMPLE_BITS = tlt_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]         rsp_sample_out,
   input  logic                                  csr_we,
   input  logic [tlt_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [tlt_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   tlt_pkg::cmd_type cmd;

   // Sequencer
   tlt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Arithmetic and state
   tlt_dp #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_sample_in  (req_sample_in),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb : self-checking bench for triangle_lfo_tremolo
// Drives signed samples over the req_ channel and checks every rsp_ sample
// against an in-bench fixed-point model of the triangle LFO and the gain
// stage. A directed opening covers sample extremes, saturation, depth and
// limit clamping, stray register bits, unused register indexes and counter
// clamping on limit writes. Random phases then change the settings between
// bursts of samples. Both sides insert random gaps, and the receiver holds
// off once for a long stretch so that back-pressure reaches the input.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SB = 24;
   localparam int CIW = tlt_pkg::CSR_IDX_W;
   localparam int CDW = tlt_pkg::CSR_DATA_W;
   localparam int unsigned ITEM_TOTAL = 1600;
   localparam int unsigned SETTLE_CYCLES = 40;     // above the result latency
   localparam int unsigned LONG_HOLD = 300;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned PRINT_CAP = 40;

   // register indexes with nothing behind them
   localparam logic [CIW-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CIW-1:0] CSR_SPARE_B = 2'd3;

   localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
   localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic signed [SB-1:0]  req_sample_in;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic signed [SB-1:0]  rsp_sample_out;
   logic                  csr_we;
   logic [CIW-1:0]        csr_index;
   logic [CDW-1:0]        csr_wdata;

   bit          tx_burst;
   bit          want_hold;
   bit          long_hold_done;
   int unsigned cycle_count = 0;

   // -------------------------------------------------------------------------
   // Scoreboard: holds its own copy of the settings and the LFO, predicts
   // one output sample per accepted input and checks results in order.
   // -------------------------------------------------------------------------
   class tremolo_scoreboard;
      int unsigned depth_reg;
      int unsigned peak_reg;
      int          tri_count;
      bit          tri_falling;
      logic signed [SB-1:0] expected_out_q[$];
      int unsigned mismatches;
      int unsigned results_seen;

      function new();
         depth_reg = tlt_pkg::DEPTH_RESET;
         peak_reg = tlt_pkg::LIMIT_RESET;
         tri_count = 0;
         tri_falling = 1'b0;
         mismatches = 0;
         results_seen = 0;
      endfunction

      function int pending();
         return expected_out_q.size();
      endfunction

      // settings write, with the block's clamping
      function void write_reg(logic [CIW-1:0] idx, logic [CDW-1:0] data);
         int unsigned peak_new;
         case (idx)
            tlt_pkg::CSR_DEPTH: begin
               depth_reg = (data > tlt_pkg::DEPTH_FULL) ? tlt_pkg::DEPTH_FULL : data;
            end
            tlt_pkg::CSR_LIMIT: begin
               peak_new = data[tlt_pkg::LIMIT_W-1:0];
               if (peak_new == 0) peak_new = 1;
               peak_reg = peak_new;
               if (tri_count > int'(peak_reg)) tri_count = int'(peak_reg);
               else if (tri_count < -int'(peak_reg)) tri_count = -int'(peak_reg);
            end
            default: ;
         endcase
      endfunction

      // predict the modulated sample, then step the triangle
      function void note_sample(logic signed [SB-1:0] sample);
         longint x, mag, ratio, gain, prod, d, lim, top, bottom;
         top = (longint'(1) <<< (SB-1)) - 1;
         bottom = -top - 1;
         x = sample;
         d = depth_reg;
         lim = peak_reg;
         mag = (tri_count < 0) ? -tri_count : tri_count;
         // count/limit in Q1.15
         ratio = (mag * tlt_pkg::DEPTH_FULL) / lim;
         if (ratio > tlt_pkg::DEPTH_FULL) ratio = tlt_pkg::DEPTH_FULL;
         if (tri_count < 0) ratio = -ratio;
         // >>> on signed longint floors toward minus infinity
         gain = ((tlt_pkg::DEPTH_FULL - d) * tlt_pkg::DEPTH_FULL + d * ratio)
                >>> tlt_pkg::Q_FRAC;
         prod = (x * gain) >>> tlt_pkg::Q_FRAC;
         if (prod > top) prod = top;
         else if (prod < bottom) prod = bottom;
         expected_out_q.push_back(prod[SB-1:0]);
         if (tri_count >= int'(peak_reg)) tri_falling = 1'b1;
         else if (tri_count <= -int'(peak_reg)) tri_falling = 1'b0;
         tri_count += tri_falling ? -1 : 1;
      endfunction

      task check_result(logic signed [SB-1:0] got);
         logic signed [SB-1:0] want;
         results_seen++;
         if (expected_out_q.size() == 0) begin
            report($sformatf("result %0d: sample_out %0d with nothing outstanding",
                             results_seen, got));
            return;
         end
         want = expected_out_q.pop_front();
         if (got !== want)
            report($sformatf("result %0d: sample_out %0d, expected %0d",
                             results_seen, got, want));
      endtask

      task report(string msg);
         mismatches++;
         if (mismatches <= PRINT_CAP) $display("tb: mismatch: %s", msg);
      endtask
   endclass

   tremolo_scoreboard tremolo_sb = new();

   triangle_lfo_tremolo #(
      .SAMPLE_BITS(SB)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample_in (req_sample_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_sample_out(rsp_sample_out),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // transaction monitor on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) tremolo_sb.note_sample(req_sample_in);
         if (rsp_valid && rsp_ready) tremolo_sb.check_result(rsp_sample_out);
      end
   end

   // mostly short gaps, a few long ones; none in burst mode
   function automatic int unsigned pick_gap(bit burst);
      int unsigned roll;
      roll = $urandom_range(99);
      if (burst) return 0;
      if (roll < 50) return 0;
      if (roll < 88) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic logic signed [SB-1:0] pick_sample();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 70) return SB'($urandom);
      if (roll < 80) begin
         case ($urandom_range(3))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return '0;
            default: return '1;
         endcase
      end
      if (roll < 90) return SB'($signed($urandom_range(512)) - 256);
      if (roll < 95) return SB'(SAMPLE_MAX - $urandom_range(64));
      return SB'(SAMPLE_MIN + $urandom_range(64));
   endfunction

   // one input transaction; valid stays up when no gap follows
   task automatic send_sample(input logic signed [SB-1:0] x);
      int unsigned gap;
      req_valid <= 1'b1;
      req_sample_in <= x;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      gap = pick_gap(tx_burst);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // settings write; caller lowers csr_we after the last one
   task automatic csr_write(input logic [CIW-1:0] idx, input logic [CDW-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      tremolo_sb.write_reg(idx, data);
   endtask

   // stop offering, wait for all results, then let the datapath settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tremolo_sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // receiver: random ready pattern plus one long hold-off
   initial begin
      int unsigned run;
      int unsigned stall;
      bit          rx_burst;
      rsp_ready <= 1'b0;
      long_hold_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (want_hold && !long_hold_done) begin
            long_hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         rx_burst = ($urandom_range(9) == 0);
         rsp_ready <= 1'b1;
         run = rx_burst ? $urandom_range(80, 20) : $urandom_range(6, 1);
         repeat (run) @(posedge clock);
         stall = pick_gap(rx_burst);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // main sequence
   initial begin
      int unsigned sent;
      int unsigned phase;
      int unsigned n;
      int unsigned roll;
      int unsigned depth_val;
      int unsigned peak_val;
      logic [CDW-1:0] peak_data;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_sample_in <= '0;
      csr_we <= 1'b0;
      csr_index <= tlt_pkg::CSR_DEPTH;
      csr_wdata <= '0;
      tx_burst = 1'b0;
      want_hold = 1'b0;
      sent = 0;
      phase = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, sample extremes
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample('0);
      send_sample('1);
      drain();

      // depth above full and zero limit; limit write clamps the counter down,
      // full depth at count -limit drives the minimum sample into saturation
      csr_write(tlt_pkg::CSR_DEPTH, 16'hFFFF);
      csr_write(tlt_pkg::CSR_LIMIT, '0);
      csr_we <= 1'b0;
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      drain();

      // zero depth passes samples through; walk the counter negative
      csr_write(tlt_pkg::CSR_DEPTH, '0);
      csr_write(tlt_pkg::CSR_LIMIT, 16'd3);
      csr_we <= 1'b0;
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      drain();

      // negative counter clamp, stray limit bits, unused indexes
      csr_write(tlt_pkg::CSR_LIMIT, 16'd1);
      csr_write(tlt_pkg::CSR_DEPTH, CDW'(tlt_pkg::DEPTH_FULL));
      csr_write(tlt_pkg::CSR_LIMIT, 16'hFFFF);
      csr_write(CSR_SPARE_A, 16'h5A5A);
      csr_write(CSR_SPARE_B, 16'hA5A5);
      csr_we <= 1'b0;
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(24'sd1);
      send_sample(SB'(SAMPLE_MIN + 1));
      drain();

      // random phases, new settings between them
      while (sent < ITEM_TOTAL) begin
         phase++;
         roll = $urandom_range(99);
         if (roll < 20) depth_val = 0;
         else if (roll < 40) depth_val = tlt_pkg::DEPTH_FULL;
         else if (roll < 50) depth_val = $urandom_range(65535, tlt_pkg::DEPTH_FULL + 1);
         else depth_val = $urandom_range(tlt_pkg::DEPTH_FULL);
         roll = $urandom_range(99);
         if (roll < 10) peak_val = 0;
         else if (roll < 20) peak_val = (1 << tlt_pkg::LIMIT_W) - 1;
         else if (roll < 70) peak_val = $urandom_range(64, 1);
         else peak_val = $urandom_range(3000, 65);
         peak_data = {2'($urandom_range(3)), 14'(peak_val)};

         roll = $urandom_range(99);
         if (roll < 70) begin
            csr_write(tlt_pkg::CSR_DEPTH, CDW'(depth_val));
            csr_write(tlt_pkg::CSR_LIMIT, peak_data);
         end else if (roll < 85) begin
            csr_write(tlt_pkg::CSR_DEPTH, CDW'(depth_val));
         end else begin
            csr_write(tlt_pkg::CSR_LIMIT, peak_data);
         end
         if ($urandom_range(9) == 0)
            csr_write($urandom_range(1) ? CSR_SPARE_A : CSR_SPARE_B, CDW'($urandom));
         csr_we <= 1'b0;

         tx_burst = ($urandom_range(3) == 0);
         n = $urandom_range(160, 40);
         // back-pressure phase: sender keeps offering while receiver holds
         if (phase == 3) begin
            n = 240;
            tx_burst = 1'b1;
            want_hold = 1'b1;
         end
         repeat (n) begin
            send_sample(pick_sample());
            sent++;
         end
         drain();
      end

      if (tremolo_sb.mismatches == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/tlt_pkg.sv
rtl/tlt_ctrl.sv
rtl/tlt_dp.sv
rtl/triangle_lfo_tremolo.sv
bench/tb.sv
